FILE: hw/rtl/cvr_pkg.sv
// Shared types, constants and helpers for the channel volume ramp.
// Used by cvr_cell and channel_volume_ramp; depends on nothing.
package cvr_pkg;

    localparam int CHANNELS  = 8;
    localparam int GAIN_BITS = 24;
    localparam int FIELD_W   = 24;
    localparam int CHAN_W    = 4;
    localparam int IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [GAIN_BITS-1:0] UNITY_RESET = GAIN_BITS'(65536);
    localparam logic [FIELD_W-1:0]   STEP_RESET  = FIELD_W'(4096);
    localparam logic [FIELD_W-1:0]   UNITY_CFG   = FIELD_W'(65536);

    typedef enum logic [1:0] {
        KIND_SET    = 2'd0,
        KIND_SWITCH = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_READ   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        REG_MIN   = 2'd0,
        REG_MAX   = 2'd1,
        REG_STEP  = 2'd2,
        REG_UNITY = 2'd3
    } t_reg;

    typedef enum logic {
        ST_IDLE,
        ST_TICK_OUT
    } t_state;

    typedef struct packed {
        logic [GAIN_BITS-1:0] mn;
        logic [GAIN_BITS-1:0] mx;
        logic [GAIN_BITS-1:0] step;
    } t_lim;

    typedef struct packed {
        logic                 tick;
        logic                 shift;
        logic                 set_tgt;
        logic [GAIN_BITS-1:0] tgt_val;
        logic                 set_saved;
        logic [GAIN_BITS-1:0] saved_val;
    } t_cell_ctl;

    typedef struct packed {
        logic [GAIN_BITS-1:0] cur;
        logic [GAIN_BITS-1:0] tgt;
    } t_snap;

    function automatic logic [GAIN_BITS-1:0] to_gain(input logic [FIELD_W-1:0] v);
        return GAIN_BITS'(v);
    endfunction

    function automatic logic [FIELD_W-1:0] to_field(input logic [GAIN_BITS-1:0] g);
        return FIELD_W'(g);
    endfunction

endpackage

FILE: hw/rtl/cvr_cell.sv
// One channel cell: current, target and saved gain, ramp step logic,
// and a snapshot stage of the result chain. Depends on cvr_pkg.
module cvr_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cvr_pkg::t_lim     i_lim,
    input  cvr_pkg::t_cell_ctl i_ctl,
    input  logic              i_sel,
    input  cvr_pkg::t_snap    i_next,
    output cvr_pkg::t_snap    o_snap,
    output logic [cvr_pkg::GAIN_BITS-1:0] o_cur,
    output logic [cvr_pkg::GAIN_BITS-1:0] o_tgt,
    output logic [cvr_pkg::GAIN_BITS-1:0] o_saved,
    output logic              o_again
);
    import cvr_pkg::*;

    logic [GAIN_BITS-1:0] r_cur, r_tgt, r_saved, n_cur;
    logic [GAIN_BITS:0]   sum;
    logic [GAIN_BITS-1:0] diff;
    logic                 again;
    t_snap                r_snap;

    always_comb begin
        sum   = {1'b0, r_cur} + {1'b0, i_lim.step};
        diff  = r_cur - i_lim.step;
        n_cur = r_cur;
        again = 1'b0;
        if (r_cur < r_tgt) begin
            if (sum >= {1'b0, r_tgt} || sum >= {1'b0, i_lim.mx}) begin
                n_cur = r_tgt;
            end else begin
                n_cur = sum[GAIN_BITS-1:0];
                again = 1'b1;
            end
        end else if (r_cur > r_tgt) begin
            if (i_lim.step >= r_cur) begin
                n_cur = r_tgt;
            end else if (diff <= r_tgt || diff <= i_lim.mn) begin
                n_cur = r_tgt;
            end else begin
                n_cur = diff;
                again = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= UNITY_RESET;
            r_tgt   <= UNITY_RESET;
            r_saved <= '0;
        end else begin
            if (i_ctl.tick) begin
                r_cur <= n_cur;
            end
            if (i_sel && i_ctl.set_tgt) begin
                r_tgt <= i_ctl.tgt_val;
            end
            if (i_sel && i_ctl.set_saved) begin
                r_saved <= i_ctl.saved_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.tick) begin
            r_snap <= '{cur: n_cur, tgt: r_tgt};
        end else if (i_ctl.shift) begin
            r_snap <= i_next;
        end
    end

    assign o_snap  = r_snap;
    assign o_cur   = r_cur;
    assign o_tgt   = r_tgt;
    assign o_saved = r_saved;
    assign o_again = again & i_ctl.tick;

endmodule

FILE: hw/rtl/channel_volume_ramp.sv
// Top level of the per-channel volume ramp with mute and restore.
// Depends on cvr_pkg and cvr_cell (one cell per channel, chained).
//
// Usage:
//   Slave stream carries commands: tuser = kind, tdata = channel, value.
//   Master stream carries results: tdata = channel, current, target gain;
//   tuser = still_ramping, bad_channel; tlast marks an item's final result.
//   Config channel writes min, max, step and unity registers; always ready,
//   write only while the block is idle.
// Flow:
//   Set, switch and read place one result in the output register on
//   acceptance; a new item may be taken every cycle.
//   A tick steps all cells at once on acceptance, then the snapshot chain
//   shifts one channel per cycle to the output while it is not stalled:
//   CHANNELS results, channel 0 first; the next item is taken once the
//   last one sits in the output register.
// Reset: current and target gains go to unity (65536), saved gains to 0,
//   registers to their defaults, output empty.
// Stall: a held output register freezes the chain; no result is dropped.
module channel_volume_ramp (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [3:0] channel, [27:4] value, [31:28] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // [3:0] out_channel, [27:4] current_gain,
                                     // [51:28] target_gain, [55:52] zero
    output logic [1:0]  o_m_tuser,   // [0] still_ramping, [1] bad_channel
    output logic        o_m_tlast,   // last
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);
    import cvr_pkg::*;

    t_state r_state, n_state;
    logic [FIELD_W-1:0] r_min, r_max, r_step, r_unity;
    logic [IDX_W-1:0]   r_cnt, n_cnt;
    logic               r_again, n_again;

    logic               r_ovalid, n_ovalid;
    logic [CHAN_W-1:0]  r_ochan, n_ochan;
    logic [FIELD_W-1:0] r_ocur, n_ocur, r_otgt, n_otgt;
    logic               r_oramp, n_oramp, r_obad, n_obad, r_olast, n_olast;

    t_lim      lim;
    t_cell_ctl ctl;
    t_snap     snap  [CHANNELS];
    t_snap     nxt   [CHANNELS];
    logic [GAIN_BITS-1:0] cur_a [CHANNELS];
    logic [GAIN_BITS-1:0] tgt_a [CHANNELS];
    logic [GAIN_BITS-1:0] sav_a [CHANNELS];
    logic [CHANNELS-1:0]  again_v;
    logic [CHANNELS-1:0]  sel_v;

    logic                 s_acc, out_free;
    t_kind                kind;
    logic [CHAN_W-1:0]    ch;
    logic [IDX_W-1:0]     idx;
    logic                 bad;
    logic [GAIN_BITS-1:0] val, clamped, sel_cur, sel_tgt, sel_sav, new_tgt;

    assign lim.mn   = to_gain(r_min);
    assign lim.mx   = (r_max == '0 || r_max < r_min) ? to_gain(r_unity) : to_gain(r_max);
    assign lim.step = to_gain(r_step);

    assign kind = t_kind'(i_s_tuser);
    assign ch   = i_s_tdata[CHAN_W-1:0];
    assign val  = to_gain(i_s_tdata[CHAN_W +: FIELD_W]);
    assign idx  = IDX_W'(ch);
    assign bad  = {1'b0, ch} >= (CHAN_W + 1)'(CHANNELS);

    assign out_free   = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && out_free;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
        if (g == CHANNELS - 1) begin : g_end
            assign nxt[g] = '0;
        end else begin : g_mid
            assign nxt[g] = snap[g+1];
        end
        assign sel_v[g] = (idx == IDX_W'(g));
        cvr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_lim   (lim),
            .i_ctl   (ctl),
            .i_sel   (sel_v[g]),
            .i_next  (nxt[g]),
            .o_snap  (snap[g]),
            .o_cur   (cur_a[g]),
            .o_tgt   (tgt_a[g]),
            .o_saved (sav_a[g]),
            .o_again (again_v[g])
        );
    end

    assign sel_cur = cur_a[idx];
    assign sel_tgt = tgt_a[idx];
    assign sel_sav = sav_a[idx];

    always_comb begin
        clamped = val;
        if (clamped <= lim.mn) begin
            clamped = lim.mn;
        end
        if (clamped > lim.mx) begin
            clamped = lim.mx;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_again  = r_again;
        n_ovalid = r_ovalid && !i_m_tready;
        n_ochan  = r_ochan;
        n_ocur   = r_ocur;
        n_otgt   = r_otgt;
        n_oramp  = r_oramp;
        n_obad   = r_obad;
        n_olast  = r_olast;
        ctl      = '0;
        new_tgt  = sel_tgt;

        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    if (kind == KIND_TICK) begin
                        ctl.tick = 1'b1;
                        n_again  = |again_v;
                        n_cnt    = '0;
                        n_state  = ST_TICK_OUT;
                    end else if (bad) begin
                        n_ovalid = 1'b1;
                        n_ochan  = ch;
                        n_ocur   = '0;
                        n_otgt   = '0;
                        n_oramp  = 1'b0;
                        n_obad   = 1'b1;
                        n_olast  = 1'b1;
                    end else begin
                        unique case (kind)
                            KIND_SET: begin
                                new_tgt     = clamped;
                                ctl.set_tgt = 1'b1;
                            end
                            KIND_SWITCH: begin
                                if (val == '0) begin
                                    new_tgt       = '0;
                                    ctl.set_tgt   = 1'b1;
                                    ctl.set_saved = (sel_cur != '0);
                                end else if (sel_cur == '0) begin
                                    new_tgt     = sel_sav;
                                    ctl.set_tgt = 1'b1;
                                end
                            end
                            default: begin
                            end
                        endcase
                        ctl.tgt_val   = new_tgt;
                        ctl.saved_val = sel_cur;
                        n_ovalid = 1'b1;
                        n_ochan  = ch;
                        n_ocur   = to_field(sel_cur);
                        n_otgt   = to_field(new_tgt);
                        n_oramp  = 1'b0;
                        n_obad   = 1'b0;
                        n_olast  = 1'b1;
                    end
                end
            end
            ST_TICK_OUT: begin
                if (out_free) begin
                    ctl.shift = 1'b1;
                    n_ovalid  = 1'b1;
                    n_ochan   = CHAN_W'(r_cnt);
                    n_ocur    = to_field(snap[0].cur);
                    n_otgt    = to_field(snap[0].tgt);
                    n_oramp   = r_again;
                    n_obad    = 1'b0;
                    n_olast   = (r_cnt == IDX_W'(CHANNELS - 1));
                    n_cnt     = r_cnt + 1'b1;
                    if (r_cnt == IDX_W'(CHANNELS - 1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_again  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_again  <= n_again;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ochan <= n_ochan;
        r_ocur  <= n_ocur;
        r_otgt  <= n_otgt;
        r_oramp <= n_oramp;
        r_obad  <= n_obad;
        r_olast <= n_olast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= '0;
            r_max   <= '0;
            r_step  <= STEP_RESET;
            r_unity <= UNITY_CFG;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg'(i_cfg_index))
                REG_MIN:   r_min   <= i_cfg_data;
                REG_MAX:   r_max   <= i_cfg_data;
                REG_STEP:  r_step  <= i_cfg_data;
                REG_UNITY: r_unity <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {4'b0, r_otgt, r_ocur, r_ochan};
    assign o_m_tuser  = {r_obad, r_oramp};
    assign o_m_tlast  = r_olast;

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_obad) |-> (r_ocur == '0 && r_otgt == '0 && r_olast))
        else $error("bad channel result carries gains");

    a_ramp_not_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_oramp) |-> !r_obad)
        else $error("ramp flag on bad channel result");

    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_m_tready && !r_olast) |=> (r_ovalid || r_state == ST_TICK_OUT))
        else $error("tick run ended before last result");

    a_last_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TICK_OUT && out_free && r_cnt == IDX_W'(CHANNELS - 1))
        |=> (r_state == ST_IDLE && r_olast && r_ochan == CHAN_W'(CHANNELS - 1)))
        else $error("tick run did not end on final channel");

endmodule

FILE: sim/channel_volume_ramp_test.sv
// Self-checking testbench for channel_volume_ramp: directed table, then random items.
// Results are checked against a per-channel gain ramp predictor, or a typed table row.
// Depends on cvr_pkg and the channel_volume_ramp RTL.
module channel_volume_ramp_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cvr_pkg::*;

    localparam logic [23:0] UNITY      = 24'd65536;
    localparam logic [23:0] FULL       = 24'hFFFFFF;
    localparam int          SETTLE     = CHANNELS + 4;
    localparam int          IDLE_LIMIT = 2000;
    localparam int          PHASES     = 7;
    localparam int          BURST      = 15;

    typedef struct {
        logic [3:0]  chan;
        logic [23:0] cur;
        logic [23:0] tgt;
        logic        ramping;
        logic        bad;
        logic        last;
    } t_gain_result;

    typedef struct packed {
        logic        cfg;
        t_reg        idx;
        t_kind       kind;
        logic [3:0]  ch;
        logic [23:0] value;
        logic        typed;
        logic [23:0] cur;
        logic [23:0] tgt;
        logic        bad;
    } t_stim_row;

    localparam int DIR_N = 30;
    localparam t_stim_row DIR_ROWS [DIR_N] = '{
        '{1'b0, REG_MIN,   KIND_READ,   4'd0,  24'd0,     1'b1, UNITY, UNITY,     1'b0},
        '{1'b0, REG_MIN,   KIND_READ,   4'd7,  FULL,      1'b1, UNITY, UNITY,     1'b0},
        '{1'b0, REG_MIN,   KIND_READ,   4'd8,  24'd0,     1'b1, '0,    '0,        1'b1},
        '{1'b0, REG_MIN,   KIND_SET,    4'd15, FULL,      1'b1, '0,    '0,        1'b1},
        '{1'b0, REG_MIN,   KIND_SWITCH, 4'd12, 24'd0,     1'b1, '0,    '0,        1'b1},
        '{1'b0, REG_MIN,   KIND_TICK,   4'd15, FULL,      1'b0, '0,    '0,        1'b0},
        '{1'b0, REG_MIN,   KIND_SET,    4'd0,  FULL,      1'b1, UNITY, UNITY,     1'b0},
        '{1'b0, REG_MIN,   KIND_SET,    4'd1,  24'd0,     1'b1, UNITY, '0,        1'b0},
        '{1'b0, REG_MIN,   KIND_SET,    4'd2,  24'd60000, 1'b1, UNITY, 24'd60000, 1'b0},
        '{1'b0, REG_MIN,   KIND_SWITCH, 4'd3,  24'd0,     1'b1, UNITY, '0,        1'b0},
        '{1'b0, REG_MIN,   KIND_SWITCH, 4'd3,  24'd1,     1'b0, '0,    '0,        1'b0},
        '{1'b0, REG_MIN,   KIND_TICK,   4'd0,  24'd0,     1'b0, '0,    '0,        1'b0},
        '{1'b1, REG_STEP,  KIND_READ,   4'd0,  FULL,      1'b0, '0,    '0,        1'b0},
        '{1'b0, REG_MIN,   KIND_TICK,   4'd0,  24'd0,     1'b0, '0,    '0,        1'b0},
        '{1'b0, REG_MIN,   KIND_SWITCH, 4'd3,  24'd5,     1'b0, '0,    '0,        1'b0},
        '{1'b0, REG_MIN,   KIND_SWITCH, 4'd3,  24'd0,     1'b0, '0,    '0,        1'b0},
        '{1'b0, REG_MIN,   KIND_SWITCH, 4'd3,  FULL,      1'b0, '0,    '0,        1'b0},
        '{1'b0, REG_MIN,   KIND_TICK,   4'd0,  24'd0,     1'b0, '0,    '0,        1'b0},
        '{1'b1, REG_MIN,   KIND_READ,   4'd0,  FULL,      1'b0, '0,    '0,        1'b0},
        '{1'b0, REG_MIN,   KIND_SET,    4'd5,  24'd0,     1'b0, '0,    '0,        1'b0},
        '{1'b1, REG_UNITY, KIND_READ,   4'd0,  FULL,      1'b0, '0,    '0,        1'b0},
        '{1'b1, REG_MAX,   KIND_READ,   4'd0,  24'd100,   1'b0, '0,    '0,        1'b0},
        '{1'b0, REG_MIN,   KIND_SET,    4'd6,  24'd5,     1'b0, '0,    '0,        1'b0},
        '{1'b0, REG_MIN,   KIND_SET,    4'd7,  FULL,      1'b0, '0,    '0,        1'b0},
        '{1'b1, REG_STEP,  KIND_READ,   4'd0,  24'd1,     1'b0, '0,    '0,        1'b0},
        '{1'b1, REG_MIN,   KIND_READ,   4'd0,  24'd0,     1'b0, '0,    '0,        1'b0},
        '{1'b0, REG_MIN,   KIND_TICK,   4'd3,  24'd0,     1'b0, '0,    '0,        1'b0},
        '{1'b0, REG_MIN,   KIND_TICK,   4'd0,  24'd0,     1'b0, '0,    '0,        1'b0},
        '{1'b0, REG_MIN,   KIND_READ,   4'd6,  24'd0,     1'b0, '0,    '0,        1'b0},
        '{1'b0, REG_MIN,   KIND_SWITCH, 4'd7,  24'd0,     1'b0, '0,    '0,        1'b0}
    };

    // min, max, step, unity
    localparam logic [23:0] PHASE_CFG [5][4] = '{
        '{24'd0,     24'd0,      24'd4096, 24'd65536},
        '{24'd1000,  24'd200000, 24'd1,    24'd65536},
        '{24'd0,     FULL,       FULL,     24'd1},
        '{24'd50000, 24'd20000,  24'd3000, FULL},
        '{FULL,      24'd0,      24'd777,  24'h800000}
    };

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic [31:0] i_s_tdata   = '0;
    logic [1:0]  i_s_tuser   = '0;
    logic        i_m_tready  = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data  = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [55:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        o_m_tlast;
    logic        o_cfg_ready;

    channel_volume_ramp DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    logic [23:0] cur_gain   [CHANNELS];
    logic [23:0] tgt_gain   [CHANNELS];
    logic [23:0] saved_gain [CHANNELS];
    logic [23:0] lvl_min;
    logic [23:0] lvl_max;
    logic [23:0] step_size;
    logic [23:0] lvl_unity;

    t_gain_result gain_due_q[$];
    t_gain_result due;

    bit          calm;
    int unsigned out_hold;
    int unsigned out_draw;
    int          idle_cycles;
    int          errors;
    int          items_sent;
    int          ticks_sent;
    int          results_seen;
    int          cfg_writes;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void predict_gain_item(input t_kind kind, input logic [3:0] ch,
                                              input logic [23:0] value);
        logic [24:0]  nv;
        logic [23:0]  mx;
        logic [23:0]  v;
        logic         again;
        t_gain_result r;
        int           i;
        mx    = (lvl_max == '0 || lvl_max < lvl_min) ? lvl_unity : lvl_max;
        again = 1'b0;
        if (kind == KIND_TICK) begin
            for (i = 0; i < CHANNELS; i++) begin
                if (cur_gain[i] < tgt_gain[i]) begin
                    nv = {1'b0, cur_gain[i]} + {1'b0, step_size};
                    if (nv >= {1'b0, tgt_gain[i]} || nv >= {1'b0, mx}) begin
                        cur_gain[i] = tgt_gain[i];
                    end else begin
                        cur_gain[i] = nv[23:0];
                        again = 1'b1;
                    end
                end else if (cur_gain[i] > tgt_gain[i]) begin
                    if (step_size >= cur_gain[i]) begin
                        cur_gain[i] = tgt_gain[i];
                    end else begin
                        nv = {1'b0, cur_gain[i] - step_size};
                        if (nv[23:0] <= tgt_gain[i] || nv[23:0] <= lvl_min) begin
                            cur_gain[i] = tgt_gain[i];
                        end else begin
                            cur_gain[i] = nv[23:0];
                            again = 1'b1;
                        end
                    end
                end
            end
            for (i = 0; i < CHANNELS; i++) begin
                r = '{4'(i), cur_gain[i], tgt_gain[i], again, 1'b0, i == CHANNELS - 1};
                gain_due_q.push_back(r);
            end
        end else if (ch >= CHANNELS) begin
            gain_due_q.push_back('{ch, 24'd0, 24'd0, 1'b0, 1'b1, 1'b1});
        end else begin
            case (kind)
                KIND_SET: begin
                    v = value;
                    if (v <= lvl_min)
                        v = lvl_min;
                    if (v > mx)
                        v = mx;
                    tgt_gain[ch] = v;
                end
                KIND_SWITCH: begin
                    if (value == '0) begin
                        if (cur_gain[ch] != '0)
                            saved_gain[ch] = cur_gain[ch];
                        tgt_gain[ch] = '0;
                    end else if (cur_gain[ch] == '0) begin
                        tgt_gain[ch] = saved_gain[ch];
                    end
                end
                default: ;
            endcase
            gain_due_q.push_back('{ch, cur_gain[ch], tgt_gain[ch], 1'b0, 1'b0, 1'b1});
        end
    endfunction

    function automatic void check_field(input string name, input logic [23:0] want,
                                        input logic [23:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic logic [3:0] pick_channel();
        if ($urandom_range(0, 6) == 0)
            return 4'($urandom_range(CHANNELS, 15));
        return 4'($urandom_range(0, CHANNELS - 1));
    endfunction

    function automatic logic [23:0] pick_level();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return FULL;
            2: return lvl_min;
            3: return lvl_min + 24'd1;
            4: return lvl_max;
            5: return lvl_unity;
            6: return 24'($urandom);
            default: return 24'($urandom_range(0, 24'h1FFFF));
        endcase
    endfunction

    task automatic send_item(input t_kind kind, input logic [3:0] ch, input logic [23:0] value);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0, value, ch};
        i_s_tuser  <= kind;
        do @(posedge i_clk); while (!o_s_tready);
        predict_gain_item(kind, ch, value);
        items_sent++;
        if (kind == KIND_TICK)
            ticks_sent++;
    endtask

    // registers change only with the block drained
    task automatic write_cfg(input t_reg idx, input logic [23:0] data);
        i_s_tvalid <= 1'b0;
        while (gain_due_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_MIN:  lvl_min   = data;
            REG_MAX:  lvl_max   = data;
            REG_STEP: step_size = data;
            default:  lvl_unity = data;
        endcase
        cfg_writes++;
    endtask

    task automatic send_tick();
        send_item(KIND_TICK, 4'($urandom), 24'($urandom));
    endtask

    task automatic run_random_burst(input int n);
        int         done;
        int         reps;
        logic [3:0] ch;
        done = 0;
        while (done < n) begin
            ch = pick_channel();
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    send_item(KIND_SET, ch, pick_level());
                    reps = $urandom_range(1, 4);
                    repeat (reps) send_tick();
                    done += reps + 1;
                end
                3: begin
                    // mute, ramp down over 1 to 3 ticks, then switch back on and tick
                    send_item(KIND_SWITCH, ch, '0);
                    reps = $urandom_range(1, 3);
                    repeat (reps) send_tick();
                    send_item(KIND_SWITCH, ch, 24'($urandom_range(1, FULL)));
                    send_tick();
                    done += reps + 3;
                end
                4, 5: begin
                    send_tick();
                    done++;
                end
                6: begin
                    send_item(KIND_READ, ch, 24'($urandom));
                    done++;
                end
                7: begin
                    send_item(KIND_SWITCH, ch,
                              $urandom_range(0, 1) ? '0 : 24'($urandom_range(1, FULL)));
                    done++;
                end
                8: begin
                    send_item(KIND_SET, ch, pick_level());
                    done++;
                end
                default: begin
                    send_item(t_kind'($urandom_range(0, 3)), 4'($urandom), 24'($urandom));
                    done++;
                end
            endcase
        end
    endtask

    // result side: random stall per item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            out_hold   <= 0;
        end else if (out_hold != 0) begin
            out_hold   <= out_hold - 1;
            i_m_tready <= (out_hold == 1);
        end else if (o_m_tvalid && i_m_tready) begin
            out_draw   = calm ? 0 : $urandom_range(0, 6);
            out_hold   <= out_draw;
            i_m_tready <= (out_draw == 0);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (gain_due_q.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got chan %0d cur 0x%0h",
                         $time, o_m_tdata[3:0], o_m_tdata[27:4]);
                errors++;
            end else begin
                due = gain_due_q.pop_front();
                check_field("out_channel", 24'(due.chan), 24'(o_m_tdata[3:0]));
                check_field("current_gain", due.cur, o_m_tdata[27:4]);
                check_field("target_gain", due.tgt, o_m_tdata[51:28]);
                check_field("still_ramping", 24'(due.ramping), 24'(o_m_tuser[0]));
                check_field("bad_channel", 24'(due.bad), 24'(o_m_tuser[1]));
                check_field("last", 24'(due.last), 24'(o_m_tlast));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t ns: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("channel_volume_ramp_test: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int        r;
        int        p;
        t_stim_row row;
        idle_cycles = 0;
        errors      = 0;
        calm        = 1'b0;
        lvl_min     = '0;
        lvl_max     = '0;
        step_size   = 24'd4096;
        lvl_unity   = UNITY;
        for (r = 0; r < CHANNELS; r++) begin
            cur_gain[r]   = UNITY;
            tgt_gain[r]   = UNITY;
            saved_gain[r] = '0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < DIR_N; r++) begin
            row = DIR_ROWS[r];
            if (row.cfg) begin
                write_cfg(row.idx, row.value);
            end else begin
                send_item(row.kind, row.ch, row.value);
                if (row.typed) begin
                    void'(gain_due_q.pop_back());
                    gain_due_q.push_back('{row.ch, row.cur, row.tgt, 1'b0, row.bad, 1'b1});
                end
            end
        end

        for (p = 0; p < PHASES; p++) begin
            if (p < 5) begin
                write_cfg(REG_MIN,   PHASE_CFG[p][0]);
                write_cfg(REG_MAX,   PHASE_CFG[p][1]);
                write_cfg(REG_STEP,  PHASE_CFG[p][2]);
                write_cfg(REG_UNITY, PHASE_CFG[p][3]);
            end else if (p == 5) begin
                write_cfg(REG_MIN,   24'($urandom));
                write_cfg(REG_MAX,   24'($urandom));
                write_cfg(REG_STEP,  24'($urandom_range(1, FULL)));
                write_cfg(REG_UNITY, 24'($urandom_range(1, FULL)));
            end else begin
                write_cfg(REG_MIN,   24'($urandom_range(0, 40000)));
                write_cfg(REG_MAX,   24'($urandom_range(0, 150000)));
                write_cfg(REG_STEP,  24'($urandom_range(1, 20000)));
                write_cfg(REG_UNITY, 24'($urandom_range(1, 100000)));
            end
            calm = ($urandom_range(0, 3) == 0);
            run_random_burst(BURST);
            calm = ($urandom_range(0, 3) == 0);
            run_random_burst(BURST);
        end

        i_s_tvalid <= 1'b0;
        while (gain_due_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("Covered %0d items (%0d ticks) and %0d results over %0d register writes,",
                 items_sent, ticks_sent, results_seen, cfg_writes);
        $display("with directed extremes and %0d register settings.", PHASES);
        if (errors == 0) begin
            $display("channel_volume_ramp_test: PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("channel_volume_ramp_test: FAIL");
        end
        $finish;
    end

endmodule

FILE: channel_volume_ramp.f
hw/rtl/cvr_pkg.sv
hw/rtl/cvr_cell.sv
hw/rtl/channel_volume_ramp.sv
sim/channel_volume_ramp_test.sv
